### rtl/fan_speed_ramp_controller_unit_macros.svh
`ifndef FAN_SPEED_RAMP_CONTROLLER_UNIT_MACROS_SVH
`define FAN_SPEED_RAMP_CONTROLLER_UNIT_MACROS_SVH

// clocked check, off during reset
`define FSR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication check, off during reset
`define FSR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/fsr_pkg.sv
package fsr_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int MUL_A_W    = 16;
  localparam int MUL_B_W    = 8;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
  localparam int DIV_N_W    = 24;
  localparam int DIV_D_W    = 9;

  typedef struct packed {
    logic [7:0] rate;
    logic       sensor_ok;
  } fsr_in_t;

  typedef struct packed {
    logic [6:0] applied_power;
    logic [6:0] target_power;
    logic       fan_on;
    logic       indicator;
  } fsr_out_t;

  typedef struct packed {
    logic [7:0]  min_rate;
    logic [7:0]  max_rate;
    logic [6:0]  base_speed;
    logic [6:0]  top_speed;
    logic [6:0]  ramp_step;
    logic [15:0] ramp_interval;
    logic [15:0] blink_slow;
    logic [15:0] blink_fast;
  } fsr_cfg_t;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_RATE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RATE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_SPEED     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_INTERVAL = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_SLOW    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_FAST    = 3'd7;

  localparam fsr_cfg_t CFG_RESET = '{
    min_rate:      8'd100,
    max_rate:      8'd170,
    base_speed:    7'd30,
    top_speed:     7'd100,
    ramp_step:     7'd4,
    ramp_interval: 16'd100,
    blink_slow:    16'd1000,
    blink_fast:    16'd60
  };

  localparam logic [DIV_D_W-1:0] LAMP_SCALE = 9'd100;
  localparam logic [15:0]        CNT_MAX    = 16'hFFFF;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_MUL1 = 9'b000000010,
    ST_MUL2 = 9'b000000100,
    ST_MDIV = 9'b000001000,
    ST_RAMP = 9'b000010000,
    ST_LMUL = 9'b000100000,
    ST_LDIV = 9'b001000000,
    ST_LAMP = 9'b010000000,
    ST_DONE = 9'b100000000
  } fsr_state_t;

endpackage

### rtl/fan_speed_ramp_controller_unit.sv
// channel  | direction | handshake          | word
// in_      | input     | in_valid/in_ready  | fsr_in_t: rate, sensor_ok
// out_     | output    | out_valid/out_ready| fsr_out_t: applied, target, fan_on, indicator
// cfg_     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
//
// one word at a time; the serial units set how long a word takes: the 8-step
// serial multiplier runs twice for the map and once for the lamp, and the
// 24-step serial divider runs once for each; with the fan off neither runs
// synchronous active-low reset clears state and loads the default registers
// a finished word waits in the output register while the next word is taken
`include "fan_speed_ramp_controller_unit_macros.svh"

module fan_speed_ramp_controller_unit import fsr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  fsr_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output fsr_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  fsr_cfg_t   cfg;
  fsr_state_t state_r, state_nxt;

  logic [7:0]  rate_r, rate_nxt;
  logic        enabled_r, enabled_nxt, lamp_r, lamp_nxt;
  logic [6:0]  target_r, target_nxt, applied_r, applied_nxt;
  logic [15:0] ramp_el_r, ramp_el_nxt, blink_el_r, blink_el_nxt;
  logic [15:0] total_r, total_nxt, half_r, half_nxt;
  logic        out_valid_r, out_valid_nxt;
  fsr_out_t    out_data_r, out_data_nxt;
  logic        out_load;

  logic               mul_start, mul_done;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_prod;
  logic               div_start, div_done;
  logic [DIV_N_W-1:0] div_n, div_quo;
  logic [DIV_D_W-1:0] div_d;

  logic        in_fire, healthy;
  logic [7:0]  den;
  logic [16:0] map_sum, map_num;
  logic [15:0] ramp_inc, blink_inc;
  logic [7:0]  up_sum;
  logic [6:0]  up_next, dn_val, dn_next, step_val, applied_ramp;
  logic        ramp_go;
  logic        blink_neg;
  logic [15:0] blink_mag;
  logic [16:0] lamp_q;
  logic [17:0] half_sum;
  logic [15:0] half_calc;

  fsr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fsr_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  fsr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quo      (div_quo)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign healthy   = in_data.sensor_ok && (in_data.rate >= cfg.min_rate);
  assign den       = cfg.max_rate - cfg.min_rate;

  // total = base*(max-rate) + top*(rate-min), rounded by (2*total+den)/(2*den)
  assign map_sum   = {1'b0, total_r} + {1'b0, mul_prod[15:0]};
  assign map_num   = {map_sum[15:0], 1'b0} + {9'd0, den};

  assign ramp_inc  = (ramp_el_r == CNT_MAX) ? ramp_el_r : ramp_el_r + 16'd1;
  assign blink_inc = (blink_el_r == CNT_MAX) ? blink_el_r : blink_el_r + 16'd1;

  assign up_sum    = {1'b0, applied_r} + {1'b0, cfg.ramp_step};
  assign up_next   = (up_sum > {1'b0, target_r}) ? target_r : up_sum[6:0];
  assign dn_val    = (applied_r >= cfg.ramp_step) ? applied_r - cfg.ramp_step : 7'd0;
  assign dn_next   = (dn_val < target_r) ? target_r : dn_val;
  assign step_val  = (applied_r < target_r) ? up_next : dn_next;
  assign ramp_go   = (applied_r != target_r) && (ramp_inc >= cfg.ramp_interval);
  assign applied_ramp = ramp_go ? step_val : applied_r;

  assign blink_neg = cfg.blink_slow > cfg.blink_fast;
  assign blink_mag = blink_neg ? cfg.blink_slow - cfg.blink_fast
                               : cfg.blink_fast - cfg.blink_slow;

  // half period = slow +/- trunc(applied*|fast-slow|/100), clamped to 16 bits
  assign lamp_q    = div_quo[16:0];
  assign half_sum  = {2'b00, cfg.blink_slow} + {1'b0, lamp_q};
  always_comb begin
    if (blink_neg) begin
      half_calc = (lamp_q > {1'b0, cfg.blink_slow}) ? 16'd0
                                                    : cfg.blink_slow - lamp_q[15:0];
    end else begin
      half_calc = (half_sum[17:16] != 2'b00) ? CNT_MAX : half_sum[15:0];
    end
  end

  always_comb begin
    state_nxt    = state_r;
    rate_nxt     = rate_r;
    enabled_nxt  = enabled_r;
    target_nxt   = target_r;
    applied_nxt  = applied_r;
    ramp_el_nxt  = ramp_el_r;
    blink_el_nxt = blink_el_r;
    lamp_nxt     = lamp_r;
    total_nxt    = total_r;
    half_nxt     = half_r;
    out_load     = 1'b0;
    mul_start    = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;
    div_n        = '0;
    div_d        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          rate_nxt = in_data.rate;
          if (!healthy) begin
            enabled_nxt = 1'b0;
            target_nxt  = 7'd0;
            applied_nxt = 7'd0;
            state_nxt   = ST_RAMP;
          end else begin
            enabled_nxt = 1'b1;
            if (in_data.rate <= cfg.min_rate) begin
              target_nxt = cfg.base_speed;
              state_nxt  = ST_RAMP;
            end else if (in_data.rate >= cfg.max_rate) begin
              target_nxt = cfg.top_speed;
              state_nxt  = ST_RAMP;
            end else begin
              mul_start = 1'b1;
              mul_a     = {9'd0, cfg.base_speed};
              mul_b     = cfg.max_rate - in_data.rate;
              state_nxt = ST_MUL1;
            end
          end
        end
      end
      ST_MUL1: begin
        if (mul_done) begin
          total_nxt = mul_prod[15:0];
          mul_start = 1'b1;
          mul_a     = {9'd0, cfg.top_speed};
          mul_b     = rate_r - cfg.min_rate;
          state_nxt = ST_MUL2;
        end
      end
      ST_MUL2: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_n     = {7'd0, map_num};
          div_d     = {den, 1'b0};
          state_nxt = ST_MDIV;
        end
      end
      ST_MDIV: begin
        if (div_done) begin
          target_nxt = div_quo[6:0];
          state_nxt  = ST_RAMP;
        end
      end
      ST_RAMP: begin
        ramp_el_nxt = ramp_go ? 16'd0 : ramp_inc;
        applied_nxt = applied_ramp;
        if (enabled_r) begin
          mul_start = 1'b1;
          mul_a     = blink_mag;
          mul_b     = {1'b0, applied_ramp};
          state_nxt = ST_LMUL;
        end else begin
          state_nxt = ST_LAMP;
        end
      end
      ST_LMUL: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_n     = mul_prod;
          div_d     = LAMP_SCALE;
          state_nxt = ST_LDIV;
        end
      end
      ST_LDIV: begin
        if (div_done) begin
          half_nxt  = half_calc;
          state_nxt = ST_LAMP;
        end
      end
      ST_LAMP: begin
        if (!enabled_r) begin
          lamp_nxt     = 1'b0;
          blink_el_nxt = blink_inc;
        end else if (blink_inc >= half_r) begin
          lamp_nxt     = !lamp_r;
          blink_el_nxt = 16'd0;
        end else begin
          blink_el_nxt = blink_inc;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_data_nxt = out_data_r;
    if (out_load) begin
      out_data_nxt.applied_power = applied_r;
      out_data_nxt.target_power  = target_r;
      out_data_nxt.fan_on        = enabled_r;
      out_data_nxt.indicator     = enabled_r && lamp_r;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      enabled_r   <= 1'b0;
      target_r    <= 7'd0;
      applied_r   <= 7'd0;
      ramp_el_r   <= 16'd0;
      blink_el_r  <= 16'd0;
      lamp_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      enabled_r   <= enabled_nxt;
      target_r    <= target_nxt;
      applied_r   <= applied_nxt;
      ramp_el_r   <= ramp_el_nxt;
      blink_el_r  <= blink_el_nxt;
      lamp_r      <= lamp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rate_r     <= rate_nxt;
    total_r    <= total_nxt;
    half_r     <= half_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `FSR_ASSERT_IMP(a_off_zero, !enabled_r,
    (applied_r == 7'd0) && (target_r == 7'd0), "fan off with nonzero power")
  `FSR_ASSERT_IMP(a_mul_owner, mul_done,
    (state_r == ST_MUL1) || (state_r == ST_MUL2) || (state_r == ST_LMUL),
    "multiplier result outside a multiply state")
  `FSR_ASSERT_IMP(a_div_owner, div_done,
    (state_r == ST_MDIV) || (state_r == ST_LDIV), "divider result outside a divide state")
  `FSR_ASSERT_IMP(a_out_load, $rose(out_valid_r),
    $past(state_r) == ST_DONE, "result word loaded outside done state")

endmodule

### rtl/fsr_cfg_regs.sv
module fsr_cfg_regs import fsr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output fsr_cfg_t              cfg
);

  fsr_cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_MIN_RATE:      cfg_nxt.min_rate      = cfg_data[7:0];
        REG_MAX_RATE:      cfg_nxt.max_rate      = cfg_data[7:0];
        REG_BASE_SPEED:    cfg_nxt.base_speed    = cfg_data[6:0];
        REG_TOP_SPEED:     cfg_nxt.top_speed     = cfg_data[6:0];
        REG_RAMP_STEP:     cfg_nxt.ramp_step     = cfg_data[6:0];
        REG_RAMP_INTERVAL: cfg_nxt.ramp_interval = cfg_data;
        REG_BLINK_SLOW:    cfg_nxt.blink_slow    = cfg_data;
        REG_BLINK_FAST:    cfg_nxt.blink_fast    = cfg_data;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### rtl/fsr_mul.sv
module fsr_mul import fsr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic               done,
  output logic [MUL_P_W-1:0] prod
);

  logic [MUL_A_W-1:0] a_r, a_nxt, hi_r, hi_nxt;
  logic [MUL_B_W-1:0] lo_r, lo_nxt;
  logic [2:0]         cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt, done_r, done_nxt;
  logic [MUL_A_W:0]   sum;

  // shift-add, one multiplier bit per cycle, lsb first
  always_comb begin
    sum      = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : '0);
    a_nxt    = a_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = a;
      hi_nxt   = '0;
      lo_nxt   = b;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      hi_nxt  = sum[MUL_A_W:1];
      lo_nxt  = {sum[0], lo_r[MUL_B_W-1:1]};
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == 3'(MUL_B_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r  <= a_nxt;
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
  end

  assign done = done_r;
  assign prod = {hi_r, lo_r};

endmodule

### rtl/fsr_div.sv
module fsr_div import fsr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DIV_N_W-1:0] dividend,
  input  logic [DIV_D_W-1:0] divisor,
  output logic               done,
  output logic [DIV_N_W-1:0] quo
);

  logic [DIV_N_W-1:0] quo_r, quo_nxt;
  logic [DIV_D_W-1:0] rem_r, rem_nxt, dsr_r, dsr_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt, done_r, done_nxt;
  logic [DIV_D_W+1:0] diff;

  // restoring division, one quotient bit per cycle, msb first
  always_comb begin
    diff     = {1'b0, rem_r, quo_r[DIV_N_W-1]} - {2'b00, dsr_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[DIV_D_W+1]) begin
        rem_nxt = diff[DIV_D_W-1:0];
        quo_nxt = {quo_r[DIV_N_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[DIV_D_W-2:0], quo_r[DIV_N_W-1]};
        quo_nxt = {quo_r[DIV_N_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(DIV_N_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
